// ----- sv/mcr_pkg.sv -----
`default_nettype none

package mcr_pkg;

  // fixed field widths
  localparam int COORD_BITS_DEF = 12;
  localparam int XY_W           = 13;
  localparam int DEC_W          = 18;
  localparam int PIX_W          = 14;
  localparam int COLOR_W        = 32;
  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 1;
  localparam int QUEUE_DEPTH    = 2;

  // eight octant pixels per step
  localparam int OCTANTS = 8;
  localparam int K_W     = $clog2(OCTANTS);
  localparam logic [K_W-1:0] K_LAST = K_W'(OCTANTS - 1);

  // result stream payload
  localparam int OUT_DATA_W  = 2 * PIX_W + COLOR_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     SCREEN_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0]     SCREEN_HEIGHT_RST = CFG_W'(480);

  // opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // decision update constants
  localparam logic [DEC_W-1:0] DEC_INIT   = DEC_W'(3);
  localparam logic [DEC_W-1:0] DEC_INC_E  = DEC_W'(6);
  localparam logic [DEC_W-1:0] DEC_INC_SE = DEC_W'(10);

  // one queued step: current point, flags and color
  typedef struct packed {
    logic               marker;
    logic               done;
    logic [XY_W-1:0]    x;
    logic [XY_W-1:0]    y;
    logic [COLOR_W-1:0] color;
  } job_t;

endpackage

`default_nettype wire

// ----- sv/mcr_front.sv -----
`default_nettype none

module mcr_front import mcr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  output logic                       s_ready_o,
  input  wire logic                  opcode_i,
  input  wire logic [COORD_BITS-1:0] center_x_i,
  input  wire logic [COORD_BITS-1:0] center_y_i,
  input  wire logic [COORD_BITS-1:0] radius_i,
  input  wire logic [COLOR_W-1:0]    color_i,
  input  wire logic                  q_ready_i,
  output logic                       push_o,
  output job_t                       job_o,
  output logic [COORD_BITS-1:0]      job_cx_o,
  output logic [COORD_BITS-1:0]      job_cy_o
);

  logic                  active_q, active_d;
  logic [DEC_W-1:0]      dec_q, dec_d;
  logic [XY_W-1:0]       x_q, x_d, y_q, y_d;
  logic [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [COLOR_W-1:0]    color_q, color_d;

  logic                  accept;
  logic [DEC_W-1:0]      dec_step;
  logic [XY_W-1:0]       y_step;
  logic signed [XY_W+1:0] nx_s, ny_s;
  logic                  done;

  assign s_ready_o = q_ready_i;
  assign accept    = s_valid_i && s_ready_o;

  // midpoint decision update
  always_comb begin
    if (dec_q[DEC_W-1]) begin
      dec_step = dec_q + (DEC_W'(x_q) << 2) + DEC_INC_E;
      y_step   = y_q;
      ny_s     = signed'({2'b00, y_q});
    end else begin
      dec_step = dec_q + ((DEC_W'(x_q) - DEC_W'(y_q)) << 2) + DEC_INC_SE;
      y_step   = y_q - XY_W'(1);
      ny_s     = signed'({2'b00, y_q}) - signed'((XY_W+2)'(1));
    end
    nx_s = signed'({2'b00, x_q}) + signed'((XY_W+2)'(1));
    done = ny_s < nx_s;
  end

  always_comb begin
    active_d = active_q;
    dec_d    = dec_q;
    x_d      = x_q;
    y_d      = y_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    color_d  = color_q;
    if (accept) begin
      if (opcode_i == OP_START) begin
        active_d = 1'b1;
        dec_d    = DEC_INIT - (DEC_W'(radius_i) << 1);
        x_d      = '0;
        y_d      = XY_W'(radius_i);
        cx_d     = center_x_i;
        cy_d     = center_y_i;
        color_d  = color_i;
      end else if (active_q) begin
        dec_d = dec_step;
        x_d   = nx_s[XY_W-1:0];
        y_d   = y_step;
        if (done) begin
          active_d = 1'b0;
        end
      end
    end
  end

  assign push_o       = accept && (opcode_i == OP_STEP);
  assign job_o.marker = !active_q;
  assign job_o.done   = done;
  assign job_o.x      = x_q;
  assign job_o.y      = y_q;
  assign job_o.color  = color_q;
  assign job_cx_o     = cx_q;
  assign job_cy_o     = cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      dec_q    <= '0;
      x_q      <= '0;
      y_q      <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      color_q  <= '0;
    end else begin
      active_q <= active_d;
      dec_q    <= dec_d;
      x_q      <= x_d;
      y_q      <= y_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      color_q  <= color_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mcr_queue.sv -----
`default_nettype none

module mcr_queue import mcr_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o,
  input  wire logic             pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = count_q != CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mcr_back.sv -----
`default_nettype none

module mcr_back import mcr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                  job_valid_i,
  input  wire job_t                  job_i,
  input  wire logic [COORD_BITS-1:0] job_cx_i,
  input  wire logic [COORD_BITS-1:0] job_cy_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [PIX_W-1:0]           pixel_x_o,
  output logic [PIX_W-1:0]           pixel_y_o,
  output logic [COLOR_W-1:0]         pixel_color_o,
  output logic                       on_screen_o,
  output logic                       last_o,
  output logic                       circle_done_o
);

  localparam int SUM_W = ((COORD_BITS > XY_W) ? COORD_BITS : XY_W) + 2;

  logic [CFG_W-1:0]   width_q, height_q;
  logic [K_W-1:0]     k_q, k_d;
  logic               valid_q, valid_d;
  logic [PIX_W-1:0]   px_q, py_q;
  logic [COLOR_W-1:0] color_q;
  logic               on_q, last_q, done_q;

  logic               load, job_end;
  logic [XY_W-1:0]    ofs_col, ofs_row;
  logic [SUM_W-1:0]   px, py;
  logic               on;

  // octant select: bit 0 swaps x and y, bit 1 mirrors the column, bit 2 the row
  always_comb begin
    ofs_col = k_q[0] ? job_i.y : job_i.x;
    ofs_row = k_q[0] ? job_i.x : job_i.y;
    px = k_q[1] ? SUM_W'(job_cx_i) - SUM_W'(ofs_col) : SUM_W'(job_cx_i) + SUM_W'(ofs_col);
    py = k_q[2] ? SUM_W'(job_cy_i) - SUM_W'(ofs_row) : SUM_W'(job_cy_i) + SUM_W'(ofs_row);
    on = !px[SUM_W-1] && !py[SUM_W-1] &&
         (px < SUM_W'(width_q)) && (py < SUM_W'(height_q));
  end

  assign load    = job_valid_i && (!valid_q || out_ready_i);
  assign job_end = job_i.marker || (k_q == K_LAST);
  assign pop_o   = load && job_end;

  always_comb begin
    k_d     = k_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      k_d     = job_end ? '0 : k_q + K_W'(1);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (job_i.marker) begin
        px_q    <= '0;
        py_q    <= '0;
        color_q <= '0;
        on_q    <= 1'b0;
        last_q  <= 1'b1;
        done_q  <= 1'b1;
      end else begin
        px_q    <= px[PIX_W-1:0];
        py_q    <= py[PIX_W-1:0];
        color_q <= job_i.color;
        on_q    <= on;
        last_q  <= k_q == K_LAST;
        done_q  <= job_i.done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_WIDTH_RST;
      height_q <= SCREEN_HEIGHT_RST;
      k_q      <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
          REG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = color_q;
  assign on_screen_o   = on_q;
  assign last_o        = last_q;
  assign circle_done_o = done_q;

endmodule

`default_nettype wire

// ----- sv/midpoint_circle_rasterizer.sv -----
// midpoint circle rasterizer: a start transfer (tuser = start) latches center, radius and
// color and emits nothing; each step transfer then yields the eight octant pixels of the
// current point, one result transfer per cycle while the sink is ready, the eighth with
// tlast high, all with circle_done set on the step that ends the circle. a step with no
// circle active yields a single all-zero done marker. starts are taken one per cycle
// while the queue has room; steps are paced by the single result channel, which carries
// eight transfers per step. the front holds the circle state and updates it in the cycle
// a step is taken, a two-entry queue lets it run ahead of the pixel generator, and the
// output register holds a result until the sink takes it. screen size registers are
// written through the cfg port (index 0 width, 1 height); the user must write them only
// while the block is idle, and the block itself does not enforce this.
`default_nettype none

module midpoint_circle_rasterizer import mcr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_DATA_W  = 3 * COORD_BITS + COLOR_W,
  localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,
  // command stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // center_x, center_y, radius, color
  input  wire logic                   s_axis_tuser,  // opcode
  // pixel stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // pixel_x, pixel_y, pixel_color
  output logic                        m_axis_tlast,  // last pixel of the step
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser   // on_screen, circle_done
);

  localparam int Q_W     = 2 * COORD_BITS + $bits(job_t);
  localparam int OUT_PAD = OUT_TDATA_W - OUT_DATA_W;

  // command fields
  logic [COORD_BITS-1:0] in_cx, in_cy, in_radius;
  logic [COLOR_W-1:0]    in_color;

  assign in_cx     = s_axis_tdata[COORD_BITS-1:0];
  assign in_cy     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_radius = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign in_color  = s_axis_tdata[IN_DATA_W-1:3*COORD_BITS];

  // front to queue
  logic                  push, q_ready;
  job_t                  push_job;
  logic [COORD_BITS-1:0] push_cx, push_cy;

  // queue to back
  logic                  q_valid, pop;
  logic [Q_W-1:0]        q_data;
  job_t                  head_job;
  logic [COORD_BITS-1:0] head_cx, head_cy;

  // result fields
  logic [PIX_W-1:0]      pix_x, pix_y;
  logic [COLOR_W-1:0]    pix_color;
  logic                  pix_on, pix_done;

  mcr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .center_x_i (in_cx),
    .center_y_i (in_cy),
    .radius_i   (in_radius),
    .color_i    (in_color),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .job_o      (push_job),
    .job_cx_o   (push_cx),
    .job_cy_o   (push_cy)
  );

  mcr_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_cx, push_cy, push_job}),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  assign head_job = q_data[$bits(job_t)-1:0];
  assign head_cy  = q_data[$bits(job_t)+COORD_BITS-1:$bits(job_t)];
  assign head_cx  = q_data[Q_W-1:$bits(job_t)+COORD_BITS];

  mcr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .job_valid_i   (q_valid),
    .job_i         (head_job),
    .job_cx_i      (head_cx),
    .job_cy_i      (head_cy),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_x_o     (pix_x),
    .pixel_y_o     (pix_y),
    .pixel_color_o (pix_color),
    .on_screen_o   (pix_on),
    .last_o        (m_axis_tlast),
    .circle_done_o (pix_done)
  );

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, pix_color, pix_y, pix_x};
  assign m_axis_tuser = {pix_done, pix_on};

`ifndef SYNTHESIS
  // the front never hands a step to a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_ready)
    else $error("step pushed into full queue");

  // an on-screen pixel has non-negative coordinates
  a_on_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[PIX_W-1] == 1'b0 && m_axis_tdata[2*PIX_W-1] == 1'b0))
    else $error("on-screen pixel outside screen range");

  // octant pixels of one step follow without a gap
  a_step_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("gap inside a step's pixel burst");
`endif

endmodule

`default_nettype wire

// ----- test/tb_midpoint_circle_rasterizer.sv -----
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer;
  import mcr_pkg::*;

  // command stream packing: center_x, center_y, radius, color from the lowest bit up
  localparam int COORD      = COORD_BITS_DEF;
  localparam int IN_TDATA_W = ((3 * COORD + COLOR_W + 7) / 8) * 8;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLDOFF_CYCLES = 120;
  localparam int ITEMS_PER_SET  = 24;

  // one expected pixel transfer
  typedef struct packed {
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [COLOR_W-1:0] color;
    logic               on_screen;
    logic               last;
    logic               done;
  } pixel_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  // shared run control
  int     idle_pct     = 9;
  bit     holdoff_req  = 1'b0;
  int     mismatches   = 0;
  int     cycle_count  = 0;
  pixel_t expected_pixels[$];

  // circle tracker: screen size and the rasterizer state as the block should hold it
  logic [CFG_W-1:0]   scr_w = SCREEN_WIDTH_RST;
  logic [CFG_W-1:0]   scr_h = SCREEN_HEIGHT_RST;
  logic               circ_active = 1'b0;
  logic [DEC_W-1:0]   circ_dec    = '0;
  logic [XY_W-1:0]    circ_x      = '0;
  logic [XY_W-1:0]    circ_y      = '0;
  logic [COORD-1:0]   circ_cx     = '0;
  logic [COORD-1:0]   circ_cy     = '0;
  logic [COLOR_W-1:0] circ_color  = '0;

  midpoint_circle_rasterizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // run guard: a hung handshake ends the run here
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // rasterize one accepted command: update the tracked circle and queue its pixels
  function automatic void rasterize_cmd(input logic op, input logic [COORD-1:0] cx_in,
                                        input logic [COORD-1:0] cy_in,
                                        input logic [COORD-1:0] r_in,
                                        input logic [COLOR_W-1:0] color_in);
    int     x, y, cx, cy, d, nx, ny;
    int     ox[8], oy[8];
    logic   fin;
    pixel_t pix;
    if (op == OP_START) begin
      // a start also drops any circle still in progress
      circ_cx     = cx_in;
      circ_cy     = cy_in;
      circ_color  = color_in;
      circ_dec    = DEC_W'(3 - 2 * int'(r_in));
      circ_x      = '0;
      circ_y      = XY_W'(r_in);
      circ_active = 1'b1;
      return;
    end
    if (!circ_active) begin
      // step with no circle: single all-zero done marker
      pix = '0;
      pix.last = 1'b1;
      pix.done = 1'b1;
      expected_pixels.push_back(pix);
      return;
    end
    x  = int'(circ_x);
    y  = int'(circ_y);
    cx = int'(circ_cx);
    cy = int'(circ_cy);
    d  = int'($signed(circ_dec));
    ny = y;
    if (d < 0) begin
      d = d + 4 * x + 6;
    end else begin
      d  = d + 4 * (x - y) + 10;
      ny = y - 1;
    end
    nx  = x + 1;
    fin = (ny < nx);
    // octant order: (+x,+y) (+y,+x) (-x,+y) (-y,+x) (+x,-y) (+y,-x) (-x,-y) (-y,-x)
    ox = '{cx + x, cx + y, cx - x, cx - y, cx + x, cx + y, cx - x, cx - y};
    oy = '{cy + y, cy + x, cy + y, cy + x, cy - y, cy - x, cy - y, cy - x};
    for (int k = 0; k < OCTANTS; k++) begin
      pix.px        = PIX_W'(ox[k]);
      pix.py        = PIX_W'(oy[k]);
      pix.color     = circ_color;
      pix.on_screen = (ox[k] >= 0) && (oy[k] >= 0) &&
                      (ox[k] < int'(scr_w)) && (oy[k] < int'(scr_h));
      pix.last      = (k == OCTANTS - 1);
      pix.done      = fin;
      expected_pixels.push_back(pix);
    end
    circ_dec = DEC_W'(d);
    circ_x   = XY_W'(nx);
    circ_y   = XY_W'(ny);
    if (fin) circ_active = 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result checker: every pixel transfer against the oldest expectation
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel transfer", m_axis_tdata[31:0], 32'h0);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata[PIX_W-1:0] !== want.px)
          report_mismatch("pixel_x", m_axis_tdata[PIX_W-1:0], want.px);
        if (m_axis_tdata[2*PIX_W-1:PIX_W] !== want.py)
          report_mismatch("pixel_y", m_axis_tdata[2*PIX_W-1:PIX_W], want.py);
        if (m_axis_tdata[2*PIX_W+COLOR_W-1:2*PIX_W] !== want.color)
          report_mismatch("pixel_color", m_axis_tdata[2*PIX_W+COLOR_W-1:2*PIX_W],
                          want.color);
        if (m_axis_tuser[0] !== want.on_screen)
          report_mismatch("on_screen", m_axis_tuser[0], want.on_screen);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", m_axis_tlast, want.last);
        if (m_axis_tuser[1] !== want.done)
          report_mismatch("circle_done", m_axis_tuser[1], want.done);
      end
    end
  end

  // pixel sink: random ready, plus a long hold-off counted here when requested
  initial begin : pixel_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        stall_left  = HOLDOFF_CYCLES;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // offer one command, hold it until the transfer, then predict its pixels
  task automatic send_cmd(input logic op, input logic [COORD-1:0] cx,
                          input logic [COORD-1:0] cy, input logic [COORD-1:0] r,
                          input logic [COLOR_W-1:0] color);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(0, 99) < idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_TDATA_W'({color, r, cy, cx});
    do @(posedge clk_i); while (!s_axis_tready);
    rasterize_cmd(op, cx, cy, r, color);
  endtask

  // steps carry junk payload, the block must ignore it
  task automatic send_step();
    send_cmd(OP_STEP, COORD'($urandom), COORD'($urandom), COORD'($urandom), $urandom);
  endtask

  // drop valid, wait for every pixel, then give the back end time to go quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_screen(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
  endtask

  // center up to eight past the screen size half the time, anywhere otherwise
  function automatic logic [COORD-1:0] pick_coord(input int limit);
    if ($urandom_range(0, 1)) return COORD'($urandom_range(0, 4095));
    return COORD'($urandom_range(0, (limit > 4087) ? 4095 : limit + 8));
  endfunction

  // step right after reset: no circle yet, expect the done marker
  task automatic test_idle_step();
    send_step();
  endtask

  // zero radius: center pixel eight times, finished, then a marker
  task automatic test_zero_radius();
    send_cmd(OP_START, 12'd320, 12'd240, 12'd0, 32'h00ff_00ff);
    send_step();
    send_step();
  endtask

  // field extremes; each circle is abandoned by the next start
  task automatic test_field_extremes();
    send_cmd(OP_START, 12'hfff, 12'hfff, 12'hfff, 32'hffff_ffff);
    repeat (3) send_step();
    send_cmd(OP_START, 12'h000, 12'h000, 12'hfff, 32'h0000_0000);
    repeat (3) send_step();
  endtask

  // small circle run to the end, one step past it
  task automatic test_small_circle();
    send_cmd(OP_START, 12'd5, 12'd470, 12'd3, 32'hdead_beef);
    while (circ_active) send_step();
    send_step();
  endtask

  // sink holds off while steps keep coming: queue fills and input stalls
  task automatic test_backpressure();
    holdoff_req = 1'b1;
    send_cmd(OP_START, 12'd100, 12'd100, 12'd20, 32'h1234_5678);
    repeat (16) send_step();
  endtask

  // random circles over several screen sizes, mostly well-formed sequences
  task automatic test_random_circles();
    logic [CFG_W-1:0] widths[7];
    logic [CFG_W-1:0] heights[7];
    int               sent, n;
    logic [COORD-1:0] r;
    widths  = '{13'd0, 13'd8191, 13'd1, 13'd4096, CFG_W'($urandom_range(1, 4096)),
                CFG_W'($urandom_range(1, 64)), SCREEN_WIDTH_RST};
    heights = '{13'd0, 13'd8191, 13'd1, 13'd4096, CFG_W'($urandom_range(1, 4096)),
                CFG_W'($urandom_range(1, 64)), SCREEN_HEIGHT_RST};
    for (int p = 0; p < 7; p++) begin
      write_screen(REG_SCREEN_WIDTH, widths[p]);
      write_screen(REG_SCREEN_HEIGHT, heights[p]);
      // one whole set with no idling on either side
      idle_pct = (p == 1) ? 0 : 9;
      sent = 0;
      while (sent < ITEMS_PER_SET) begin
        if ($urandom_range(0, 99) < 80) begin
          r = ($urandom_range(0, 9) == 0) ? COORD'($urandom_range(0, 4095))
                                          : COORD'($urandom_range(0, 24));
          send_cmd(OP_START, pick_coord(widths[p]), pick_coord(heights[p]), r, $urandom);
          sent++;
          if (r <= 24 && $urandom_range(0, 99) < 70) begin
            while (circ_active) begin
              send_step();
              sent++;
            end
          end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
              send_step();
              sent++;
            end
          end
        end else begin
          // noise: stray step (marker when idle) or a lone start
          if ($urandom_range(0, 1)) send_step();
          else send_cmd(OP_START, COORD'($urandom), COORD'($urandom), COORD'($urandom),
                        $urandom);
          sent++;
        end
      end
    end
    idle_pct = 9;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_step();
    test_zero_radius();
    test_field_extremes();
    test_small_circle();
    test_backpressure();
    test_random_circles();

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
